// ===== design/dcaf_pkg.sv =====
package dcaf_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned FillW = IdxW + 1;
  localparam int unsigned XfadeFrames = 32;
  localparam int unsigned MaxPop = 64;
  localparam int unsigned AvgW = 27;

  localparam logic [1:0] RegTarget = 2'd0;
  localparam logic [1:0] RegDeadband = 2'd1;
  localparam logic [1:0] RegShift = 2'd2;

  localparam logic CmdPush = 1'b0;
  localparam logic CmdPop = 1'b1;

  typedef enum logic [2:0] {
    OpNone = 3'd0,
    OpPush = 3'd1,
    OpEma = 3'd2,
    OpDecide = 3'd3,
    OpFade = 3'd4,
    OpDup = 3'd5,
    OpCopy = 3'd6,
    OpEmpty = 3'd7
  } op_e;

  typedef struct packed {
    op_e op;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic drop;
    logic dup;
    logic fifo_empty;
    logic div_busy;
    logic done_count;
    logic fade_left;
  } stat_t;

  typedef struct packed {
    logic signed [15:0] ch0;
    logic signed [15:0] ch1;
    logic frame_valid;
    logic last;
    logic [10:0] fill_level;
    logic [26:0] average_fill;
    logic [31:0] fix_count;
  } res_t;

endpackage

// ===== design/dcaf_if.sv =====
interface dcaf_in_if;
  logic valid;
  logic ready;
  logic command;
  logic signed [15:0] sample_ch0;
  logic signed [15:0] sample_ch1;
  logic [6:0] max_frames;
  modport source(output valid, command, sample_ch0, sample_ch1, max_frames, input ready);
  modport sink(input valid, command, sample_ch0, sample_ch1, max_frames, output ready);
endinterface

interface dcaf_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] out_ch0;
  logic signed [15:0] out_ch1;
  logic frame_valid;
  logic last;
  logic [10:0] fill_level;
  logic [26:0] average_fill;
  logic [31:0] fix_count;
  modport source(output valid, out_ch0, out_ch1, frame_valid, last, fill_level,
                 average_fill, fix_count, input ready);
  modport sink(input valid, out_ch0, out_ch1, frame_valid, last, fill_level,
               average_fill, fix_count, output ready);
endinterface

interface dcaf_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/dcaf_divider.sv =====
module dcaf_divider (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [22:0] num_i,
  input  logic [6:0] den_i,
  output logic busy_o,
  output logic [15:0] quot_o
);

  logic [22:0] rem_q, rem_d;
  logic [22:0] num_q, num_d;
  logic [6:0] den_q;
  logic [4:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [23:0] trial;

  assign trial = {rem_q, num_q[22]};

  always_comb begin
    rem_d = rem_q;
    num_d = num_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d = '0;
      num_d = num_i;
      cnt_d = 5'd23;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[21:0], 1'b0};
      if (trial >= {17'd0, den_q}) begin
        rem_d = 23'(trial - {17'd0, den_q});
        num_d[0] = 1'b1;
      end else begin
        rem_d = trial[22:0];
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = busy_q;
  assign quot_o = num_q[15:0];

endmodule

// ===== design/dcaf_datapath.sv =====
module dcaf_datapath (
  input  logic clk_i,
  input  logic rst_ni,
  input  dcaf_pkg::ctrl_t ctrl_i,
  output dcaf_pkg::stat_t stat_o,
  input  logic [15:0] push_c0_i,
  input  logic [15:0] push_c1_i,
  input  logic [6:0] max_frames_i,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output dcaf_pkg::res_t res_o
);

  logic [31:0] ring [dcaf_pkg::Capacity];
  logic [31:0] head_q;
  logic [dcaf_pkg::IdxW-1:0] rd_q, wr_q;
  logic [dcaf_pkg::FillW-1:0] fill_q;
  logic [dcaf_pkg::AvgW-1:0] avg_q;
  logic [31:0] prev_q, fix_q;
  logic [10:0] target_q, dead_q;
  logic [3:0] shift_q;
  logic [6:0] maxf_q, k_q, n_q, i_q;
  logic [5:0] ch_sel_q;
  logic [15:0] blend_q [2];
  logic [1:0] ch_q;
  logic div_start, div_busy;
  logic [15:0] div_quot;
  logic [22:0] div_num;
  logic [6:0] div_den;
  logic [6:0] wa, wb;
  logic signed [15:0] pa, pb;
  logic [dcaf_pkg::FillW-1:0] fill_after;
  logic [dcaf_pkg::IdxW-1:0] rd_next;
  logic [27:0] goal, hi, lo;
  logic [27:0] diff;
  logic [27:0] step;
  logic [6:0] n_calc;
  logic [31:0] blended;
  logic fade;
  logic k_last;

  assign fade = (ctrl_i.op == dcaf_pkg::OpFade);
  assign k_last = (k_q + 7'd1 >= maxf_q);
  assign wa = fade ? 7'(n_q - i_q) : 7'd1;
  assign wb = fade ? 7'(i_q + 7'd1) : 7'd1;
  assign pa = ch_sel_q[1] ? prev_q[31:16] : prev_q[15:0];
  assign pb = ch_sel_q[1] ? head_q[31:16] : head_q[15:0];
  assign div_den = 7'(wa + wb);
  assign div_num = 23'($signed({pa[15], pa}) * $signed({1'b0, wa}))
                 + 23'($signed({pb[15], pb}) * $signed({1'b0, wb}))
                 + 23'({16'd0, div_den} << 15) + 23'({16'd0, div_den} >> 1);
  assign div_start = (ctrl_i.op == dcaf_pkg::OpFade || ctrl_i.op == dcaf_pkg::OpDup)
                     && !ctrl_i.emit && !div_busy && ch_sel_q[0];

  dcaf_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quot_o(div_quot)
  );

  assign blended = {16'(blend_q[1] - 16'h8000), 16'(blend_q[0] - 16'h8000)};
  assign rd_next = rd_q + 1'b1;
  assign goal = {1'b0, fill_q, 16'd0};
  assign hi = {5'd0, 12'(target_q + dead_q), 11'd0} << 5;
  assign lo = (dead_q < target_q) ? {6'd0, 11'(target_q - dead_q), 11'd0} << 5 : '0;
  assign diff = (goal >= {1'b0, avg_q}) ? goal - {1'b0, avg_q} : {1'b0, avg_q} - goal;
  assign step = (goal >= {1'b0, avg_q}) ? diff >> shift_q
              : (diff + ((28'd1 << shift_q) - 28'd1)) >> shift_q;
  assign fill_after = fill_q - 1'b1;
  assign n_calc = (fill_after < 11'(dcaf_pkg::XfadeFrames))
                ? ((7'(fill_after) < maxf_q) ? 7'(fill_after) : maxf_q)
                : ((7'(dcaf_pkg::XfadeFrames) < maxf_q) ? 7'(dcaf_pkg::XfadeFrames) : maxf_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == dcaf_pkg::OpPush) ring[wr_q] <= {push_c1_i, push_c0_i};
    head_q <= ring[rd_q];
    if (div_start) ch_q <= ch_sel_q[1] ? 2'd1 : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
      fill_q <= '0;
      avg_q <= 27'(256) << 16;
      prev_q <= '0;
      fix_q <= '0;
      target_q <= 11'd256;
      dead_q <= 11'd32;
      shift_q <= 4'd6;
      maxf_q <= '0;
      k_q <= '0;
      n_q <= '0;
      i_q <= '0;
      ch_sel_q <= 6'd1;
      blend_q[0] <= '0;
      blend_q[1] <= '0;
      res_o <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dcaf_pkg::RegTarget: begin
            target_q <= cfg_data_i[10:0];
            avg_q <= {cfg_data_i[10:0], 16'd0};
          end
          dcaf_pkg::RegDeadband: dead_q <= cfg_data_i[10:0];
          dcaf_pkg::RegShift: shift_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      case (ctrl_i.op)
        dcaf_pkg::OpPush: begin
          wr_q <= wr_q + 1'b1;
          if (fill_q >= dcaf_pkg::FillW'(dcaf_pkg::Capacity)) rd_q <= rd_next;
          else fill_q <= fill_q + 1'b1;
        end
        dcaf_pkg::OpEma: begin
          maxf_q <= (max_frames_i > 7'(dcaf_pkg::MaxPop)) ? 7'(dcaf_pkg::MaxPop)
                                                          : max_frames_i;
          k_q <= '0;
          i_q <= '0;
          if (goal >= {1'b0, avg_q}) avg_q <= 27'({1'b0, avg_q} + step);
          else avg_q <= 27'({1'b0, avg_q} - step);
        end
        dcaf_pkg::OpDecide: begin
          if ({1'b0, avg_q} > hi && fill_q != '0) begin
            fix_q <= fix_q + 1'b1;
            rd_q <= rd_next;
            fill_q <= fill_after;
            n_q <= n_calc;
          end else if ({1'b0, avg_q} < lo && fill_q != '0) begin
            fix_q <= fix_q + 1'b1;
          end
        end
        dcaf_pkg::OpFade, dcaf_pkg::OpDup: begin
          if (ctrl_i.emit) begin
            if (!fade || i_q + 7'd1 == n_q) prev_q <= blended;
            res_o <= '{ch0: blended[15:0], ch1: blended[31:16], frame_valid: 1'b1,
                       last: k_last || (fade && fill_after == '0),
                       fill_level: (fade ? fill_after : fill_q),
                       average_fill: avg_q, fix_count: fix_q};
            k_q <= k_q + 1'b1;
            if (fade) begin
              i_q <= i_q + 1'b1;
              rd_q <= rd_next;
              fill_q <= fill_after;
            end
            ch_sel_q <= 6'd1;
          end else if (!div_busy && !ch_sel_q[0] && ch_sel_q != '0) begin
            blend_q[ch_q[0]] <= div_quot;
            ch_sel_q <= ch_q[0] ? 6'd0 : 6'd3;
          end else if (div_start) begin
            ch_sel_q <= 6'd2;
          end
        end
        dcaf_pkg::OpCopy: begin
          prev_q <= head_q;
          rd_q <= rd_next;
          fill_q <= fill_after;
          k_q <= k_q + 1'b1;
          res_o <= '{ch0: head_q[15:0], ch1: head_q[31:16], frame_valid: 1'b1,
                     last: k_last || (fill_after == '0), fill_level: fill_after,
                     average_fill: avg_q, fix_count: fix_q};
        end
        dcaf_pkg::OpEmpty: begin
          res_o <= '{ch0: '0, ch1: '0, frame_valid: 1'b0, last: 1'b1,
                     fill_level: fill_q, average_fill: avg_q, fix_count: fix_q};
        end
        default: ;
      endcase
    end
  end

  assign stat_o.drop = ({1'b0, avg_q} > hi) && fill_q != '0;
  assign stat_o.dup = ({1'b0, avg_q} < lo) && fill_q != '0;
  assign stat_o.fifo_empty = (fill_q == '0);
  assign stat_o.div_busy = div_busy || div_start || (ch_sel_q != '0);
  assign stat_o.done_count = (k_q >= maxf_q);
  assign stat_o.fade_left = (i_q < n_q);

endmodule

// ===== design/dcaf_controller.sv =====
module dcaf_controller (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_cmd_i,
  input  logic [6:0] in_maxf_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  dcaf_pkg::stat_t stat_i,
  output dcaf_pkg::ctrl_t ctrl_o
);

  typedef enum logic [8:0] {
    SIdle = 9'b000000001,
    SEma = 9'b000000010,
    SDecide = 9'b000000100,
    SFade = 9'b000001000,
    SDup = 9'b000010000,
    SRead = 9'b000100000,
    SCopy = 9'b001000000,
    SOut = 9'b010000000,
    SEmpty = 9'b100000000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic ov_q, ov_d;
  logic any_q, any_d;
  logic accept;

  assign in_ready_o = (state_q == SIdle) && !ov_q;
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    any_d = any_q;
    ov_d = ov_q && !out_ready_i;
    ctrl_o = '{op: dcaf_pkg::OpNone, emit: 1'b0};
    case (state_q)
      SIdle: begin
        if (accept) begin
          if (in_cmd_i == dcaf_pkg::CmdPush) ctrl_o.op = dcaf_pkg::OpPush;
          else if (in_maxf_i != '0) begin
            ctrl_o.op = dcaf_pkg::OpEma;
            state_d = SEma;
            any_d = 1'b0;
          end
        end
      end
      SEma: begin
        ctrl_o.op = dcaf_pkg::OpDecide;
        if (stat_i.drop) state_d = SRead;
        else if (stat_i.dup) state_d = SDup;
        else state_d = SRead;
        ret_d = stat_i.drop ? SFade : SCopy;
      end
      SRead: state_d = ret_q;
      SDup, SFade: begin
        if (state_q == SFade && !stat_i.fade_left) state_d = SCopy;
        else begin
          ctrl_o.op = (state_q == SDup) ? dcaf_pkg::OpDup : dcaf_pkg::OpFade;
          if (!stat_i.div_busy && !ov_q) begin
            ctrl_o.emit = 1'b1;
            ov_d = 1'b1;
            any_d = 1'b1;
            ret_d = state_q;
            state_d = SOut;
          end
        end
      end
      SCopy: begin
        if (stat_i.done_count || stat_i.fifo_empty) begin
          if (!any_q) state_d = SEmpty;
          else state_d = SIdle;
        end else if (!ov_q) begin
          ctrl_o.op = dcaf_pkg::OpCopy;
          ov_d = 1'b1;
          any_d = 1'b1;
          ret_d = SCopy;
          state_d = SOut;
        end
      end
      SOut: begin
        if (!ov_q || out_ready_i) state_d = (ret_q == SDup) ? SRead : SRead;
        if (!ov_q || out_ready_i) ret_d = (ret_q == SDup) ? SCopy : ret_q;
      end
      SEmpty: begin
        if (!ov_q) begin
          ctrl_o.op = dcaf_pkg::OpEmpty;
          ov_d = 1'b1;
          state_d = SDecide;
        end
      end
      SDecide: begin
        if (!ov_q) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ret_q <= SIdle;
      ov_q <= 1'b0;
      any_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      ov_q <= ov_d;
      any_q <= any_d;
    end
  end

endmodule

// ===== design/drift_corrected_audio_fifo.sv =====
// Drift-corrected stereo audio FIFO.
// The input channel carries words that either push one frame (command 0) or
// request up to max_frames frames (command 1). Pushes produce no result. A
// pop produces one result word per frame, the last marked by last, or a
// single invalid word marked last when nothing is emitted; a pop with
// max_frames of zero produces no word. A pop first updates the average,
// makes the decision and reads the first ring word. Each copied frame then
// passes through the result register and the following memory read. A
// crossfaded or duplicated frame is computed by the shared serial divider
// that runs once per channel. The configuration channel is always ready and
// writes registers target_frames, deadband_frames and ema_shift by index.
// Reset empties the ring, loads the registers with their defaults and sets
// the average fill to target times 65536. The ring contents stay undefined.
// When the receiver stalls, the result word is held and the block waits;
// no new input word is accepted until a request has been fully delivered.
module drift_corrected_audio_fifo (
  input  logic clk_i,
  input  logic rst_ni,
  dcaf_in_if.sink in_if,
  dcaf_out_if.source out_if,
  dcaf_cfg_if.sink cfg_if
);

  dcaf_pkg::ctrl_t ctrl;
  dcaf_pkg::stat_t stat;
  dcaf_pkg::res_t res;

  assign cfg_if.ready = 1'b1;

  dcaf_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_cmd_i(in_if.command), .in_maxf_i(in_if.max_frames),
    .in_ready_o(in_if.ready), .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  dcaf_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .push_c0_i(in_if.sample_ch0), .push_c1_i(in_if.sample_ch1),
    .max_frames_i(in_if.max_frames),
    .cfg_we_i(cfg_if.valid), .cfg_idx_i(cfg_if.index), .cfg_data_i(cfg_if.data),
    .res_o(res)
  );

  assign out_if.out_ch0 = res.ch0;
  assign out_if.out_ch1 = res.ch1;
  assign out_if.frame_valid = res.frame_valid;
  assign out_if.last = res.last;
  assign out_if.fill_level = res.fill_level;
  assign out_if.average_fill = res.average_fill;
  assign out_if.fix_count = res.fix_count;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid)
    else $error("result word dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready)
    else $error("input accepted while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.frame_valid |-> out_if.last)
    else $error("empty result not marked last");

endmodule

// ===== bench/tb_drift_corrected_audio_fifo.sv =====
module tb_drift_corrected_audio_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic command;
    logic signed [15:0] ch0;
    logic signed [15:0] ch1;
    logic [6:0] max_frames;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dcaf_in_if in_if ();
  dcaf_out_if out_if ();
  dcaf_cfg_if cfg_if ();

  drift_corrected_audio_fifo dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  always #5 clk_i = ~clk_i;

  request_t request_q[$];
  dcaf_pkg::res_t frames_due_q[$];

  logic [31:0] ring_mem [dcaf_pkg::Capacity];
  int unsigned rd_ptr, wr_ptr, fill;
  longint unsigned avg_fill;
  logic [31:0] last_out;
  logic [31:0] fixes;
  int unsigned target_cfg, deadband_cfg, shift_cfg;

  int unsigned errors, pushes_seen, pops_seen, words_checked;
  logic in_taken, cfg_taken;
  int unsigned gap_left, burst_left;
  logic want_hold, hold_taken;
  int unsigned hold_cnt, pattern_cnt, pattern_mode;

  function automatic logic [15:0] mix(logic signed [15:0] a, logic signed [15:0] b,
                                      longint wa, longint wb);
    longint den;
    longint num;
    den = wa + wb;
    num = longint'(a) * wa + longint'(b) * wb + 32768 * den;
    return 16'((num + den / 2) / den - 32768);
  endfunction

  function automatic logic [31:0] mix_frames(logic [31:0] p, logic [31:0] q,
                                             longint wp, longint wq);
    return {mix(p[31:16], q[31:16], wp, wq), mix(p[15:0], q[15:0], wp, wq)};
  endfunction

  function automatic logic [31:0] pop_head();
    logic [31:0] f;
    f = ring_mem[rd_ptr];
    rd_ptr = (rd_ptr + 1) % dcaf_pkg::Capacity;
    fill--;
    return f;
  endfunction

  function automatic dcaf_pkg::res_t frame_word(logic [31:0] f, logic fv);
    dcaf_pkg::res_t r;
    r.ch0 = f[15:0];
    r.ch1 = f[31:16];
    r.frame_valid = fv;
    r.last = 1'b0;
    r.fill_level = fill[10:0];
    r.average_fill = avg_fill[26:0];
    r.fix_count = fixes;
    return r;
  endfunction

  function automatic void predict_request(request_t rq);
    int unsigned maxf, n;
    longint unsigned goal, hi, lo, d;
    logic [31:0] f;
    dcaf_pkg::res_t batch[$];
    if (rq.command == dcaf_pkg::CmdPush) begin
      pushes_seen++;
      if (fill >= dcaf_pkg::Capacity) void'(pop_head());
      ring_mem[wr_ptr] = {rq.ch1, rq.ch0};
      wr_ptr = (wr_ptr + 1) % dcaf_pkg::Capacity;
      fill++;
      return;
    end
    maxf = rq.max_frames;
    if (maxf == 0) return;
    pops_seen++;
    if (maxf > dcaf_pkg::MaxPop) maxf = dcaf_pkg::MaxPop;
    goal = longint'(fill) << 16;
    if (goal >= avg_fill) begin
      avg_fill += (goal - avg_fill) >> shift_cfg;
    end else begin
      d = avg_fill - goal;
      avg_fill -= (d + ((64'd1 << shift_cfg) - 1)) >> shift_cfg;
    end
    hi = longint'(target_cfg + deadband_cfg) << 16;
    lo = (deadband_cfg < target_cfg) ? longint'(target_cfg - deadband_cfg) << 16 : 0;
    if (avg_fill > hi && fill > 0) begin
      fixes++;
      void'(pop_head());
      n = dcaf_pkg::XfadeFrames;
      if (fill < n) n = fill;
      if (maxf < n) n = maxf;
      for (int unsigned i = 0; i < n; i++) begin
        f = pop_head();
        f = mix_frames(last_out, f, longint'(n - i), longint'(i + 1));
        batch.push_back(frame_word(f, 1'b1));
      end
      if (n > 0) last_out = f;
    end else if (avg_fill < lo && fill > 0) begin
      fixes++;
      last_out = mix_frames(last_out, ring_mem[rd_ptr], 1, 1);
      batch.push_back(frame_word(last_out, 1'b1));
    end
    while (batch.size() < maxf && fill > 0) begin
      f = pop_head();
      last_out = f;
      batch.push_back(frame_word(f, 1'b1));
    end
    if (batch.size() == 0) batch.push_back(frame_word(32'd0, 1'b0));
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) frames_due_q.push_back(batch[i]);
  endfunction

  // Monitor: configuration writes, accepted requests and returned words.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      cfg_taken <= cfg_if.valid && cfg_if.ready;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          dcaf_pkg::RegTarget: begin
            target_cfg = cfg_if.data[10:0];
            avg_fill = longint'(target_cfg) << 16;
          end
          dcaf_pkg::RegDeadband: deadband_cfg = cfg_if.data[10:0];
          dcaf_pkg::RegShift: shift_cfg = cfg_if.data[3:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (frames_due_q.size() == 0) begin
          $error("unexpected output word");
          errors++;
        end else begin
          dcaf_pkg::res_t e;
          e = frames_due_q.pop_front();
          words_checked++;
          if (out_if.out_ch0 !== e.ch0) begin
            $error("out_ch0: expected %0d, got %0d", e.ch0, out_if.out_ch0);
            errors++;
          end
          if (out_if.out_ch1 !== e.ch1) begin
            $error("out_ch1: expected %0d, got %0d", e.ch1, out_if.out_ch1);
            errors++;
          end
          if (out_if.frame_valid !== e.frame_valid) begin
            $error("frame_valid: expected %0d, got %0d", e.frame_valid, out_if.frame_valid);
            errors++;
          end
          if (out_if.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_if.last);
            errors++;
          end
          if (out_if.fill_level !== e.fill_level) begin
            $error("fill_level: expected %0d, got %0d", e.fill_level, out_if.fill_level);
            errors++;
          end
          if (out_if.average_fill !== e.average_fill) begin
            $error("average_fill: expected %0d, got %0d", e.average_fill,
                   out_if.average_fill);
            errors++;
          end
          if (out_if.fix_count !== e.fix_count) begin
            $error("fix_count: expected %0d, got %0d", e.fix_count, out_if.fix_count);
            errors++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        request_t rq;
        rq.command = in_if.command;
        rq.ch0 = in_if.sample_ch0;
        rq.ch1 = in_if.sample_ch1;
        rq.max_frames = in_if.max_frames;
        predict_request(rq);
      end
    end
  end

  // Request driver: bursts with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        request_t rq;
        rq = request_q.pop_front();
        in_if.command <= rq.command;
        in_if.sample_ch0 <= rq.ch0;
        in_if.sample_ch1 <= rq.ch1;
        in_if.max_frames <= rq.max_frames;
        in_if.valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall patterns plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (want_hold && !hold_taken) begin
        hold_taken = 1'b1;
        hold_cnt = 600;
      end
      if (pattern_cnt == 0) begin
        pattern_cnt = $urandom_range(20, 120);
        pattern_mode = $urandom_range(0, 3);
      end
      pattern_cnt--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        case (pattern_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 3) != 0);
          2: out_if.ready <= ($urandom_range(0, 1) != 0);
          default: out_if.ready <= (pattern_cnt % 5 != 0);
        endcase
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    @(negedge clk_i);
    cfg_if.index = idx;
    cfg_if.data = value;
    cfg_if.valid = 1'b1;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_if.valid = 1'b0;
  endtask

  task automatic settle();
    wait (request_q.size() == 0);
    do @(negedge clk_i); while (in_if.valid && !in_taken);
    wait (frames_due_q.size() == 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic configure(int unsigned tgt, int unsigned band, int unsigned sh);
    settle();
    write_reg(dcaf_pkg::RegTarget, tgt);
    write_reg(dcaf_pkg::RegDeadband, band);
    write_reg(dcaf_pkg::RegShift, sh);
  endtask

  task automatic add_push(logic signed [15:0] a, logic signed [15:0] b);
    request_t rq;
    rq.command = dcaf_pkg::CmdPush;
    rq.ch0 = a;
    rq.ch1 = b;
    rq.max_frames = 7'($urandom);
    request_q.push_back(rq);
  endtask

  task automatic add_pop(logic [6:0] mf);
    request_t rq;
    rq.command = dcaf_pkg::CmdPop;
    rq.ch0 = 16'($urandom);
    rq.ch1 = 16'($urandom);
    rq.max_frames = mf;
    request_q.push_back(rq);
  endtask

  task automatic add_random(int unsigned count, int unsigned push_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < push_pct)
        add_push(16'($urandom), 16'($urandom));
      else if ($urandom_range(0, 9) == 0)
        add_pop(7'($urandom));
      else
        add_pop(7'($urandom_range(1, 12)));
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.command = dcaf_pkg::CmdPush;
    in_if.sample_ch0 = '0;
    in_if.sample_ch1 = '0;
    in_if.max_frames = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = dcaf_pkg::RegTarget;
    cfg_if.data = '0;
    rd_ptr = 0;
    wr_ptr = 0;
    fill = 0;
    target_cfg = 256;
    deadband_cfg = 32;
    shift_cfg = 6;
    avg_fill = 64'd256 << 16;
    last_out = '0;
    fixes = '0;
    errors = 0;
    gap_left = 0;
    burst_left = 0;
    want_hold = 1'b0;
    hold_taken = 1'b0;
    hold_cnt = 0;
    pattern_cnt = 0;
    pattern_mode = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_pop(7'd1);
    add_push(16'sh7fff, -16'sh8000);
    add_push(-16'sh8000, 16'sh7fff);
    add_push(16'sh0000, -16'sh0001);
    add_push(16'sh5555, 16'shaaaa);
    add_push(16'shaaaa, 16'sh5555);
    add_pop(7'd0);
    add_pop(7'd1);
    add_pop(7'd127);
    add_pop(7'd64);
    add_push(16'sh1234, -16'sh1234);
    add_pop(7'd65);

    configure(0, 0, 1);
    for (int i = 0; i < 40; i++) add_push(16'($urandom), 16'($urandom));
    add_pop(7'd64);
    add_pop(7'd3);
    add_pop(7'd40);
    add_pop(7'd127);

    configure(1024, 0, 15);
    for (int i = 0; i < 6; i++) add_push(16'($urandom), 16'($urandom));
    add_pop(7'd2);
    add_pop(7'd1);
    add_pop(7'd127);

    // Long receiver stall while the sender keeps offering requests.
    configure(1024, 1024, 15);
    for (int i = 0; i < 40; i++) add_push(16'($urandom), 16'($urandom));
    settle();
    want_hold = 1'b1;
    for (int i = 0; i < 4; i++) add_pop(7'd12);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      configure($urandom_range(0, 40), $urandom_range(0, 12), $urandom_range(1, 15));
      add_random(22, 65);
      settle();
      add_random(22, 55);
    end
    configure(8, 2, 2);
    add_random(40, 60);
    settle();

    $display("Covered %0d pushes and %0d pops, %0d output words checked, %0d corrections.",
             pushes_seen, pops_seen, words_checked, fixes);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== drift_corrected_audio_fifo.f =====
design/dcaf_pkg.sv
design/dcaf_if.sv
design/dcaf_divider.sv
design/dcaf_datapath.sv
design/dcaf_controller.sv
design/drift_corrected_audio_fifo.sv
bench/tb_drift_corrected_audio_fifo.sv
